// ===== src/anchor_proximity_indicator_defines.svh =====
// Assertion helpers shared by the anchor proximity indicator RTL.
// Both expect aclk and aresetn in scope.
`ifndef ANCHOR_PROXIMITY_INDICATOR_DEFINES_SVH
`define ANCHOR_PROXIMITY_INDICATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define API_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define API_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/api_pkg.sv =====
`timescale 1ns / 1ps

package api_pkg;

    // Anchor table
    localparam int NUM_ANCHORS = 8;
    localparam int IDX_W       = (NUM_ANCHORS > 1) ? $clog2(NUM_ANCHORS) : 1;

    // Action codes (tick and the unused code fall through as a tick)
    localparam logic [1:0] ACT_FRAME  = 2'd0;
    localparam logic [1:0] ACT_SELECT = 2'd2;

    // Config register indexes
    localparam logic [1:0] REG_STALE = 2'd0;
    localparam logic [1:0] REG_SHOW  = 2'd1;
    localparam logic [1:0] REG_CLICK = 2'd2;

    // Reset values
    localparam logic [15:0] STALE_RST      = 16'd1500;
    localparam logic [15:0] SHOW_RST       = 16'd650;
    localparam logic [7:0]  CLICK_RST      = 8'd18;
    localparam logic [31:0] SHOW_UNTIL_RST = 32'd650;

    // Power metric: q = (cir << 17) / count^2
    localparam int PWR_SHIFT  = 17;
    localparam int DIVIDEND_W = 16 + PWR_SHIFT;
    localparam int DIVISOR_W  = 24;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);

    // Blink phase: now / 125 = (now * BLINK_RECIP) >> BLINK_SHIFT, exact for any 32-bit now
    localparam logic [28:0] BLINK_RECIP = 29'h10624DD3;
    localparam int          BLINK_SHIFT = 35;

    localparam logic [31:0] LEVEL_THR [8] = '{
        32'd300, 32'd700, 32'd1500, 32'd3000,
        32'd5500, 32'd9000, 32'd14000, 32'd22000
    };

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic [2:0]  src_anchor;
        logic [15:0] cir_growth;
        logic [11:0] preamble_count;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  led_mask;
        logic        buzzer_on;
        logic [31:0] power_q;
        logic [3:0]  power_level;
        logic [2:0]  selected_anchor;
    } out_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Number of thresholds reached (thresholds ascend)
    function automatic logic [3:0] level_of(input logic [31:0] q);
        logic [3:0] lv;
        lv = 4'd0;
        for (int i = 0; i < 8; i++) begin
            if (q >= LEVEL_THR[i]) begin
                lv = lv + 4'd1;
            end
        end
        return lv;
    endfunction

    // Click period in ms per level
    function automatic logic [10:0] click_period(input logic [3:0] lv);
        logic [10:0] p;
        case (lv)
            4'd0:    p = 11'd1400;
            4'd1:    p = 11'd1000;
            4'd2:    p = 11'd700;
            4'd3:    p = 11'd450;
            4'd4:    p = 11'd280;
            4'd5:    p = 11'd160;
            4'd6:    p = 11'd90;
            4'd7:    p = 11'd55;
            default: p = 11'd32;
        endcase
        return p;
    endfunction

endpackage

// ===== src/api_divider.sv =====
`timescale 1ns / 1ps

`include "anchor_proximity_indicator_defines.svh"

module api_divider
    import api_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output div_stat_t             stat,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [STEP_W-1:0]     cnt_reg;
    logic [DIVISOR_W-1:0]  div_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  rem_next;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVIDEND_W-1:0] quo_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  ge;

    // One restoring step: shift in next dividend bit, subtract if it fits
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, div_reg};
        ge       = shifted >= {1'b0, div_reg};
        rem_next = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], ge};
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath; quotient bits shift in as dividend bits shift out
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

    `API_ASSERT_NOW(a_no_restart, start, !busy_reg, "divider restarted while busy")
    `API_ASSERT_NXT(a_start_busy, start, busy_reg, "divider not busy after start")
    `API_ASSERT_NOW(a_done_idle, done_reg, !busy_reg, "divider done while still busy")

endmodule

// ===== src/anchor_proximity_indicator.sv =====
`timescale 1ns / 1ps
// Sequence: an accepted word goes through SQR, QSTART, LEVEL, PHASE and OUT, and a frame
// with a nonzero preamble count also waits in QWAIT on the 33-step restoring divider.
// Throughput: one word at a time, s_ready is high only in idle, so no new word is taken
// until the last one leaves OUT. The result register lets the next word in while the last result
// waits for m_ready; a result still waiting when the next word is done stalls it.
// Reset (aresetn, synchronous, active low): anchor table invalid, selection 0, buzzer off.

`include "anchor_proximity_indicator_defines.svh"

module anchor_proximity_indicator
    import api_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SQR    = 3'd1;
    localparam logic [2:0] ST_QSTART = 3'd2;
    localparam logic [2:0] ST_QWAIT  = 3'd3;
    localparam logic [2:0] ST_LEVEL  = 3'd4;
    localparam logic [2:0] ST_PHASE  = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    localparam logic [3:0]       ID_LIMIT = 4'(NUM_ANCHORS);
    localparam logic [IDX_W-1:0] SEL_LAST = IDX_W'(NUM_ANCHORS - 1);

    logic [2:0]            state_reg, state_next;
    in_item_t              item_reg;
    logic [DIVISOR_W-1:0]  sq_reg, sq_next;
    logic [31:0]           q_reg, q_next;
    logic [3:0]            lv_reg, lv_next;
    logic [1:0]            phase_reg, phase_next;

    logic [15:0]           stale_reg;
    logic [15:0]           show_reg;
    logic [7:0]            click_reg;

    logic [31:0]           seen_reg [NUM_ANCHORS];
    logic [3:0]            alvl_reg [NUM_ANCHORS];
    logic [NUM_ANCHORS-1:0] avalid_reg;
    logic [IDX_W-1:0]      sel_reg, sel_next;
    logic [31:0]           show_until_reg, show_until_next;
    logic [31:0]           next_click_reg, next_click_next;
    logic [31:0]           click_off_reg, click_off_next;
    logic                  buzz_reg, buzz_next;

    logic                  m_valid_reg, m_valid_next;
    out_item_t             m_data_reg, m_data_next;

    logic                  rec_en;
    logic [IDX_W-1:0]      rec_idx;
    logic [3:0]            rec_lv;

    logic                  div_start;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    div_stat_t             div_stat;
    logic [DIVIDEND_W-1:0] div_quotient;

    // Low bits of now * reciprocal; the two bits from BLINK_SHIFT up hold the low bits of now / 125
    logic [36:0]           blink_prod;

    // Output-stage values for the selected anchor
    logic                  in_win;
    logic                  fresh;
    logic [31:0]           age;
    logic [3:0]            sel_lv;
    logic [7:0]            led;
    logic [8:0]            bar;
    logic                  buzz_hold;

    api_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // Blink phase by reciprocal multiplication (32 x 29 bits)
    assign blink_prod = 37'(item_reg.now_ms) * 37'(BLINK_RECIP);

    // LED and freshness of the selected anchor
    always_comb begin
        in_win = item_reg.now_ms < show_until_reg;
        age    = item_reg.now_ms - seen_reg[sel_reg];
        fresh  = avalid_reg[sel_reg] && (age <= {16'd0, stale_reg});
        sel_lv = alvl_reg[sel_reg];
        bar    = (9'd1 << sel_lv) - 9'd1;
        if (in_win) begin
            led = 8'd1 << sel_reg;
        end else if (!fresh) begin
            led = 8'd0;
        end else if (sel_lv <= 4'd1) begin
            led = {7'd0, phase_reg[1]};
        end else if (sel_lv >= 4'd8) begin
            led = {8{phase_reg[0]}};
        end else begin
            led = bar[7:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        sq_next         = sq_reg;
        q_next          = q_reg;
        lv_next         = lv_reg;
        phase_next      = phase_reg;
        sel_next        = sel_reg;
        show_until_next = show_until_reg;
        next_click_next = next_click_reg;
        click_off_next  = click_off_reg;
        buzz_next       = buzz_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        rec_en          = 1'b0;
        rec_idx         = item_reg.src_anchor[IDX_W-1:0];
        rec_lv          = level_of(q_reg);
        div_start       = 1'b0;
        div_dividend    = {item_reg.cir_growth, {PWR_SHIFT{1'b0}}};
        div_divisor     = sq_reg;
        buzz_hold       = buzz_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_SQR;
                end
            end
            ST_SQR: begin
                sq_next    = {12'd0, item_reg.preamble_count}
                           * {12'd0, item_reg.preamble_count};
                state_next = ST_QSTART;
            end
            ST_QSTART: begin
                if (item_reg.action == ACT_FRAME && item_reg.preamble_count != 12'd0) begin
                    div_start  = 1'b1;
                    state_next = ST_QWAIT;
                end else begin
                    q_next     = 32'd0;
                    state_next = ST_LEVEL;
                end
            end
            ST_QWAIT: begin
                if (div_stat.done) begin
                    q_next     = div_quotient[31:0];
                    state_next = ST_LEVEL;
                end
            end
            ST_LEVEL: begin
                // Record the frame or step the selection
                lv_next = rec_lv;
                if (item_reg.action == ACT_FRAME) begin
                    rec_en = {1'b0, item_reg.src_anchor} < ID_LIMIT;
                end else if (item_reg.action == ACT_SELECT) begin
                    sel_next        = (sel_reg == SEL_LAST) ? '0 : sel_reg + 1'b1;
                    show_until_next = item_reg.now_ms + {16'd0, show_reg};
                end
                state_next = ST_PHASE;
            end
            ST_PHASE: begin
                phase_next = blink_prod[BLINK_SHIFT +: 2];
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    // Buzzer click schedule
                    if (in_win || !fresh) begin
                        buzz_next       = 1'b0;
                        next_click_next = item_reg.now_ms;
                        click_off_next  = 32'd0;
                    end else begin
                        if (buzz_reg && item_reg.now_ms >= click_off_reg) begin
                            buzz_hold = 1'b0;
                        end
                        buzz_next = buzz_hold;
                        if (item_reg.now_ms >= next_click_reg) begin
                            buzz_next       = 1'b1;
                            click_off_next  = item_reg.now_ms + {24'd0, click_reg};
                            next_click_next = item_reg.now_ms
                                            + {21'd0, click_period(sel_lv)};
                        end
                    end
                    m_valid_next                = 1'b1;
                    m_data_next.led_mask        = led;
                    m_data_next.buzzer_on       = buzz_next;
                    m_data_next.power_q         = q_reg;
                    m_data_next.power_level     = lv_reg;
                    m_data_next.selected_anchor = 3'(sel_reg);
                    state_next                  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            avalid_reg     <= '0;
            sel_reg        <= '0;
            show_until_reg <= SHOW_UNTIL_RST;
            next_click_reg <= 32'd0;
            click_off_reg  <= 32'd0;
            buzz_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
            stale_reg      <= STALE_RST;
            show_reg       <= SHOW_RST;
            click_reg      <= CLICK_RST;
        end else begin
            state_reg      <= state_next;
            sel_reg        <= sel_next;
            show_until_reg <= show_until_next;
            next_click_reg <= next_click_next;
            click_off_reg  <= click_off_next;
            buzz_reg       <= buzz_next;
            m_valid_reg    <= m_valid_next;
            if (rec_en) begin
                avalid_reg[rec_idx] <= 1'b1;
            end
            // Config writes; unknown index is dropped
            if (cfg_valid) begin
                case (cfg_index)
                    REG_STALE: stale_reg <= cfg_data;
                    REG_SHOW:  show_reg  <= cfg_data;
                    REG_CLICK: click_reg <= cfg_data[7:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_data;
        end
        sq_reg     <= sq_next;
        q_reg      <= q_next;
        lv_reg     <= lv_next;
        phase_reg  <= phase_next;
        m_data_reg <= m_data_next;
        if (rec_en) begin
            seen_reg[rec_idx] <= item_reg.now_ms;
            alvl_reg[rec_idx] <= rec_lv;
        end
    end

    `API_ASSERT_NXT(a_one_word, s_valid && s_ready, !s_ready, "accepted word while busy")
    `API_ASSERT_NOW(a_done_wait, div_stat.done, state_reg == ST_QWAIT, "divider done outside wait")
    `API_ASSERT_NOW(a_sel_range, 1'b1, sel_reg <= SEL_LAST, "selection out of range")
    `API_ASSERT_NOW(a_lvl_range, m_valid_reg, m_data_reg.power_level <= 4'd8,
        "power level above 8")

endmodule

// ===== tb/tb_anchor_proximity_indicator.sv =====
`timescale 1ns / 1ps

module tb_anchor_proximity_indicator;
    import api_pkg::*;

    // Action codes not named in the package: both behave as a time tick
    localparam logic [1:0] ACT_TICK  = 2'd1;
    localparam logic [1:0] ACT_SPARE = 2'd3;
    // Register index beyond the map, writes to it are dropped
    localparam logic [1:0] REG_NONE  = 2'd3;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_PAUSE    = 100;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    anchor_proximity_indicator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    // Idle rates in percent, changed per phase
    int src_idle_pct   = 0;
    int sink_stall_pct = 0;
    int mismatch_count = 0;
    int stall_cycles   = 0;

    // Stimulus time base in ms
    logic [31:0] clock_ms = 32'd1000;

    // Predicted result words, oldest first
    out_item_t pending_words[$];

    // Predictor copy of the indicator state and registers
    logic [31:0] seen_time [NUM_ANCHORS];
    logic [3:0]  lvl_tab   [NUM_ANCHORS];
    logic        anchor_ok [NUM_ANCHORS];
    logic [2:0]  sel_idx;
    logic [31:0] show_end;
    logic [31:0] next_click;
    logic [31:0] click_end;
    logic        buzz;
    logic [15:0] stale_lim;
    logic [15:0] show_len;
    logic [7:0]  click_len;

    task automatic reset_indicator_model();
        for (int i = 0; i < NUM_ANCHORS; i++) begin
            seen_time[i] = '0;
            lvl_tab[i]   = '0;
            anchor_ok[i] = 1'b0;
        end
        sel_idx    = '0;
        show_end   = 32'd650;
        next_click = '0;
        click_end  = '0;
        buzz       = 1'b0;
        stale_lim  = 16'd1500;
        show_len   = 16'd650;
        click_len  = 8'd18;
    endtask

    // Number of power thresholds reached
    function automatic logic [3:0] level_from_power(input logic [31:0] q);
        return 4'(q >= 32'd300) + 4'(q >= 32'd700) + 4'(q >= 32'd1500) +
               4'(q >= 32'd3000) + 4'(q >= 32'd5500) + 4'(q >= 32'd9000) +
               4'(q >= 32'd14000) + 4'(q >= 32'd22000);
    endfunction

    // Click repeat time in ms, shorter when closer
    function automatic logic [31:0] click_gap(input logic [3:0] lv);
        case (lv)
            4'd0:    return 32'd1400;
            4'd1:    return 32'd1000;
            4'd2:    return 32'd700;
            4'd3:    return 32'd450;
            4'd4:    return 32'd280;
            4'd5:    return 32'd160;
            4'd6:    return 32'd90;
            4'd7:    return 32'd55;
            default: return 32'd32;
        endcase
    endfunction

    // Apply one accepted word to the state and form the result word
    task automatic update_indicator(input in_item_t w, output out_item_t r);
        logic [63:0] square;
        logic [63:0] dividend;
        logic [31:0] q;
        logic [31:0] now;
        logic [31:0] age;
        logic [31:0] slow_phase;
        logic [31:0] fast_phase;
        logic [3:0]  lv;
        logic [3:0]  sel_lv;
        logic        fresh;
        logic [7:0]  mask;
        now = w.now_ms;
        q   = '0;
        lv  = '0;
        if (w.action == ACT_FRAME) begin
            if (w.preamble_count != '0) begin
                square   = 64'(w.preamble_count) * 64'(w.preamble_count);
                dividend = 64'(w.cir_growth) << PWR_SHIFT;
                q        = 32'(dividend / square);
            end
            lv = level_from_power(q);
            if (int'(w.src_anchor) < NUM_ANCHORS) begin
                seen_time[w.src_anchor] = now;
                lvl_tab[w.src_anchor]   = lv;
                anchor_ok[w.src_anchor] = 1'b1;
            end
        end else if (w.action == ACT_SELECT) begin
            sel_idx  = 3'((int'(sel_idx) + 1) % NUM_ANCHORS);
            show_end = now + 32'(show_len);
        end

        sel_lv     = lvl_tab[sel_idx];
        age        = now - seen_time[sel_idx];
        fresh      = anchor_ok[sel_idx] && (age <= 32'(stale_lim));
        slow_phase = now / 32'd250;
        fast_phase = now / 32'd125;

        // LED pattern
        if (now < show_end) begin
            mask = 8'd1 << sel_idx;
        end else if (!fresh) begin
            mask = 8'h00;
        end else if (sel_lv <= 4'd1) begin
            mask = slow_phase[0] ? 8'h01 : 8'h00;
        end else if (sel_lv >= 4'd8) begin
            mask = fast_phase[0] ? 8'hFF : 8'h00;
        end else begin
            mask = (8'd1 << sel_lv) - 8'd1;
        end

        // Buzzer clicks
        if (now < show_end || !fresh) begin
            buzz       = 1'b0;
            next_click = now;
            click_end  = '0;
        end else begin
            if (buzz && now >= click_end) begin
                buzz = 1'b0;
            end
            if (now >= next_click) begin
                buzz       = 1'b1;
                click_end  = now + 32'(click_len);
                next_click = now + click_gap(sel_lv);
            end
        end

        r.led_mask        = mask;
        r.buzzer_on       = buzz;
        r.power_q         = q;
        r.power_level     = lv;
        r.selected_anchor = sel_idx;
    endtask

    function automatic in_item_t make_word(input logic [1:0] act, input logic [31:0] t,
                                           input logic [2:0] id, input logic [15:0] cir,
                                           input logic [11:0] cnt);
        in_item_t w;
        w.action         = act;
        w.now_ms         = t;
        w.src_anchor     = id;
        w.cir_growth     = cir;
        w.preamble_count = cnt;
        return w;
    endfunction

    // Send one word; valid stays high afterwards until the next call or a drain
    task automatic send_word(input in_item_t w);
        out_item_t r;
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < src_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        update_indicator(w, r);
        pending_words.push_back(r);
    endtask

    // Stop sending, wait for every result, then let the block settle
    task automatic quiesce();
        s_valid <= 1'b0;
        while (pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAUSE) @(posedge aclk);
    endtask

    // Write all registers plus the unmapped index, back to back
    task automatic program_registers(input logic [15:0] stale, input logic [15:0] show,
                                     input logic [7:0] click);
        logic [1:0]  idx;
        logic [15:0] val;
        for (int i = 0; i < 4; i++) begin
            idx = 2'(i);
            case (idx)
                REG_STALE: val = stale;
                REG_SHOW:  val = show;
                REG_CLICK: val = {8'($urandom), click};
                default:   val = 16'($urandom);
            endcase
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do @(posedge aclk); while (!cfg_ready);
            case (idx)
                REG_STALE: stale_lim = val;
                REG_SHOW:  show_len  = val;
                REG_CLICK: click_len = val[7:0];
                default:   ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // Power metric corners and exact threshold hits, mostly on the selected anchor
    task automatic test_power_extremes();
        send_word(make_word(ACT_FRAME, 32'd1000, 3'd0, 16'hFFFF, 12'd0));
        send_word(make_word(ACT_FRAME, 32'd1010, 3'd0, 16'hFFFF, 12'd1));
        send_word(make_word(ACT_FRAME, 32'd1020, 3'd0, 16'h0000, 12'd4095));
        send_word(make_word(ACT_FRAME, 32'd1030, 3'd0, 16'hFFFF, 12'd4095));
        // count 512 gives q = cir / 2
        send_word(make_word(ACT_FRAME, 32'd1040, 3'd0, 16'd599, 12'd512));
        send_word(make_word(ACT_FRAME, 32'd1050, 3'd0, 16'd600, 12'd512));
        send_word(make_word(ACT_FRAME, 32'd1300, 3'd0, 16'd43998, 12'd512));
        send_word(make_word(ACT_FRAME, 32'd1400, 3'd0, 16'd44000, 12'd512));
        send_word(make_word(ACT_FRAME, 32'd1410, 3'd7, 16'd1, 12'd1));
    endtask

    // Ticks, the spare code, and a full lap of select presses
    task automatic test_actions();
        send_word(make_word(ACT_TICK, 32'd1415, 3'd5, 16'hA5A5, 12'hABC));
        send_word(make_word(ACT_SPARE, 32'd1700, 3'd2, 16'h5A5A, 12'h543));
        for (int i = 0; i < NUM_ANCHORS; i++) begin
            send_word(make_word(ACT_SELECT, 32'd2000 + 32'(i) * 32'd400, 3'(i),
                                16'd0, 12'd0));
        end
    endtask

    // Time stamps across the 32-bit wrap
    task automatic test_time_wrap();
        send_word(make_word(ACT_FRAME, 32'hFFFF_FFF0, 3'd0, 16'd3000, 12'd300));
        send_word(make_word(ACT_TICK, 32'hFFFF_FFFF, 3'd0, 16'd0, 12'd0));
        send_word(make_word(ACT_TICK, 32'h0000_0010, 3'd0, 16'd0, 12'd0));
        send_word(make_word(ACT_TICK, 32'h0000_0000, 3'd0, 16'd0, 12'd0));
        clock_ms = 32'd20;
    endtask

    // Mostly steadily advancing time with frames aimed at the selection
    task automatic test_random_traffic(input int count);
        int          roll;
        logic [1:0]  act;
        logic [2:0]  id;
        logic [11:0] cnt;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(99);
            if (roll < 70) begin
                clock_ms = clock_ms + $urandom_range(0, 40);
            end else if (roll < 95) begin
                clock_ms = clock_ms + $urandom_range(41, 2500);
            end else begin
                clock_ms = $urandom;
            end

            roll = $urandom_range(99);
            if (roll < 55) act = ACT_FRAME;
            else if (roll < 85) act = ACT_TICK;
            else if (roll < 95) act = ACT_SELECT;
            else act = ACT_SPARE;

            id = ($urandom_range(99) < 60) ? sel_idx : 3'($urandom_range(0, 7));

            roll = $urandom_range(99);
            if (roll < 80) cnt = 12'($urandom_range(150, 1500));
            else if (roll < 90) cnt = 12'($urandom);
            else if (roll < 95) cnt = 12'd0;
            else cnt = 12'($urandom_range(1, 20));

            send_word(make_word(act, clock_ms, id, 16'($urandom), cnt));
        end
        quiesce();
    endtask

    task automatic test_register_setting(input logic [15:0] stale, input logic [15:0] show,
                                         input logic [7:0] click, input int count);
        program_registers(stale, show, click);
        test_random_traffic(count);
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    // Result checker and random back-pressure
    always @(posedge aclk) begin
        out_item_t want;
        if (m_valid && m_ready) begin
            if (pending_words.size() == 0) begin
                $error("result word arrived with no prediction pending");
                mismatch_count++;
            end else begin
                want = pending_words.pop_front();
                compare_field("led_mask", 32'(want.led_mask), 32'(m_data.led_mask));
                compare_field("buzzer_on", 32'(want.buzzer_on), 32'(m_data.buzzer_on));
                compare_field("power_q", want.power_q, m_data.power_q);
                compare_field("power_level", 32'(want.power_level),
                              32'(m_data.power_level));
                compare_field("selected_anchor", 32'(want.selected_anchor),
                              32'(m_data.selected_anchor));
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        reset_indicator_model();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Sender idles more rarely than the receiver stalls
        src_idle_pct   = 32;
        sink_stall_pct = 53;
        test_power_extremes();
        test_actions();
        test_time_wrap();
        quiesce();
        test_register_setting(16'd0, 16'd0, 8'd0, 60);
        test_register_setting(16'd65535, 16'd65535, 8'd255, 60);

        // Roles swapped
        src_idle_pct   = 53;
        sink_stall_pct = 32;
        test_register_setting(16'd1500, 16'd650, 8'd18, 70);
        test_register_setting(16'($urandom_range(200, 3000)), 16'($urandom_range(0, 1000)),
                              8'($urandom), 70);

        // Full rate on both sides
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_register_setting(16'd300, 16'd100, 8'd0, 70);
        test_register_setting(16'd65535, 16'd0, 8'd255, 70);

        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+src
src/api_pkg.sv
src/api_divider.sv
src/anchor_proximity_indicator.sv
tb/tb_anchor_proximity_indicator.sv
